### design/nfcs_pkg.sv
`timescale 1ns / 1ps
// Package for the NOR flash command sequencer: operation codes, command kinds,
// flash command constants and the descriptor carried from front to back.
// No dependencies.
package nfcs_pkg;

    // Operation codes on the input tuser
    localparam logic [2:0] OP_PROGRAM = 3'd0;
    localparam logic [2:0] OP_ERASE   = 3'd1;
    localparam logic [2:0] OP_RESET   = 3'd2;
    localparam logic [2:0] OP_ID      = 3'd3;
    localparam logic [2:0] OP_CFI     = 3'd4;
    localparam logic [2:0] OP_POLL    = 3'd5;

    // Bus addresses and command bytes
    localparam logic [11:0] UNLOCK1_ADDR = 12'h555;
    localparam logic [11:0] UNLOCK2_ADDR = 12'h2AA;
    localparam logic [11:0] RESET_ADDR   = 12'h0FF;
    localparam logic [11:0] CFI_ADDR     = 12'h055;
    localparam logic [15:0] UNLOCK1_DATA = 16'h00AA;
    localparam logic [15:0] UNLOCK2_DATA = 16'h0055;
    localparam logic [15:0] PROGRAM_CMD  = 16'h00A0;
    localparam logic [15:0] ERASE_CMD    = 16'h0080;
    localparam logic [15:0] SECTOR_CMD   = 16'h0030;
    localparam logic [15:0] RESET_CMD    = 16'h00F0;
    localparam logic [15:0] ID_CMD       = 16'h0090;
    localparam logic [15:0] CFI_CMD      = 16'h0098;
    localparam logic [7:0]  LOW_BYTE     = 8'hFF;
    localparam int          Q6_BIT       = 6;

    localparam int END_W  = 25;
    localparam int STEP_W = 3;

    localparam logic [END_W-1:0] FLASH_END_RESET = 25'h0200000;

    typedef enum logic [2:0] {
        KIND_PROGRAM,
        KIND_ERASE,
        KIND_RESET,
        KIND_ID,
        KIND_CFI,
        KIND_POLL,
        KIND_ERROR
    } kind_t;

    // Classified request, minus the word address
    typedef struct packed {
        kind_t       kind;
        logic        rdy;
        logic [15:0] data;
    } cmd_t;

    // Index of the final bus write of each kind
    function automatic logic [STEP_W-1:0] last_step(input kind_t kind);
        logic [STEP_W-1:0] s;
        case (kind)
            KIND_PROGRAM: s = 3'd3;
            KIND_ERASE:   s = 3'd5;
            KIND_ID:      s = 3'd2;
            default:      s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

### design/nfcs_front.sv
`timescale 1ns / 1ps
// Front end: accepts request beats, checks range, evaluates status polls
// and classifies each request into a descriptor. Uses nfcs_pkg.
module nfcs_front #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [nfcs_pkg::END_W-1:0]    cfg_wr_data,
    input  logic                          in_fire,
    input  logic [2:0]                    operation,
    input  logic [ADDRESS_BITS-1:0]       byte_address,
    input  logic [15:0]                   write_data,
    input  logic [1:0]                    span,
    input  logic [15:0]                   status_value,
    output logic                          push,
    output nfcs_pkg::cmd_t                cmd,
    output logic [ADDRESS_BITS-2:0]       cmd_word
);

    localparam int CW = ((ADDRESS_BITS > nfcs_pkg::END_W) ? ADDRESS_BITS : nfcs_pkg::END_W) + 1;

    logic [nfcs_pkg::END_W-1:0] flash_end_reg;
    logic                       prev_toggle_reg, prev_toggle_next;
    logic                       prev_valid_reg, prev_valid_next;
    logic                       prog_err, erase_err, q6, keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_end_reg   <= nfcs_pkg::FLASH_END_RESET;
            prev_toggle_reg <= 1'b0;
            prev_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                flash_end_reg <= cfg_wr_data;
            end
            prev_toggle_reg <= prev_toggle_next;
            prev_valid_reg  <= prev_valid_next;
        end
    end

    assign prog_err  = (CW'(byte_address) + CW'(span)) > CW'(flash_end_reg);
    assign erase_err = CW'(byte_address) > CW'(flash_end_reg);
    assign q6        = status_value[nfcs_pkg::Q6_BIT];
    assign cmd_word  = byte_address[ADDRESS_BITS-1:1];

    always_comb begin
        prev_toggle_next = prev_toggle_reg;
        prev_valid_next  = prev_valid_reg;
        keep             = 1'b1;
        cmd.kind         = nfcs_pkg::KIND_ERROR;
        cmd.rdy          = 1'b0;
        cmd.data         = write_data;
        case (operation)
            nfcs_pkg::OP_PROGRAM: begin
                if (prog_err) begin
                    cmd.kind = nfcs_pkg::KIND_ERROR;
                end else begin
                    cmd.kind = nfcs_pkg::KIND_PROGRAM;
                    // drop a zero-span program once it passed the range check
                    keep     = (span != 2'd0);
                end
                if (span[0]) begin
                    cmd.data = {8'h00, write_data[7:0] & nfcs_pkg::LOW_BYTE};
                end
            end
            nfcs_pkg::OP_ERASE: begin
                cmd.kind = erase_err ? nfcs_pkg::KIND_ERROR : nfcs_pkg::KIND_ERASE;
            end
            nfcs_pkg::OP_RESET: cmd.kind = nfcs_pkg::KIND_RESET;
            nfcs_pkg::OP_ID:    cmd.kind = nfcs_pkg::KIND_ID;
            nfcs_pkg::OP_CFI:   cmd.kind = nfcs_pkg::KIND_CFI;
            nfcs_pkg::OP_POLL: begin
                cmd.kind = nfcs_pkg::KIND_POLL;
                cmd.rdy  = prev_valid_reg && (q6 == prev_toggle_reg);
            end
            default: keep = 1'b0;
        endcase
        if (in_fire) begin
            if (operation == nfcs_pkg::OP_POLL) begin
                prev_toggle_next = q6;
                prev_valid_next  = 1'b1;
            end else if (operation inside {[nfcs_pkg::OP_PROGRAM:nfcs_pkg::OP_CFI]}) begin
                prev_valid_next = 1'b0;
            end
        end
    end

    assign push = in_fire && keep;

    // a poll right after an erase command never reports ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (operation == nfcs_pkg::OP_ERASE) |=> !prev_valid_reg)
        else $error("toggle history survived a command");

    // first poll after reset or command cannot be ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && (cmd.kind == nfcs_pkg::KIND_POLL) && !prev_valid_reg |-> !cmd.rdy)
        else $error("ready reported without a previous poll");

    // every accepted poll leaves a valid toggle history
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (operation == nfcs_pkg::OP_POLL) |=> prev_valid_reg)
        else $error("poll did not record toggle bit");

endmodule

### design/nfcs_fifo.sv
`timescale 1ns / 1ps
// Small register queue between the front end and the back end.
// No package dependencies.
module nfcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("pop from empty queue");

endmodule

### design/nfcs_back.sv
`timescale 1ns / 1ps
// Back end: expands the head descriptor into result beats, one per cycle while
// the output is not stalled, into a registered output stage. Uses nfcs_pkg.
module nfcs_back #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    input  nfcs_pkg::cmd_t          head_cmd,
    input  logic [ADDRESS_BITS-2:0] head_word,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ADDRESS_BITS-2:0] out_addr,
    output logic [15:0]             out_data,
    output logic                    out_wr,
    output logic                    out_rdy,
    output logic                    out_err,
    output logic                    out_last
);

    localparam int WA = ADDRESS_BITS - 1;

    logic                        valid_reg, valid_next;
    logic [nfcs_pkg::STEP_W-1:0] step_reg, step_next;
    logic [WA-1:0]               addr_reg;
    logic [15:0]                 data_reg;
    logic                        wr_reg, rdy_reg, err_reg, last_reg;
    logic                        load;
    logic [WA-1:0]               res_addr;
    logic [15:0]                 res_data;
    logic                        res_wr, res_rdy, res_err, res_last;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && res_last;

    always_comb begin
        res_addr = '0;
        res_data = '0;
        res_wr   = 1'b1;
        res_rdy  = 1'b0;
        res_err  = 1'b0;
        case (head_cmd.kind)
            nfcs_pkg::KIND_PROGRAM: begin
                case (step_reg)
                    3'd0: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK1_ADDR);
                        res_data = nfcs_pkg::UNLOCK1_DATA;
                    end
                    3'd1: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK2_ADDR);
                        res_data = nfcs_pkg::UNLOCK2_DATA;
                    end
                    3'd2: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK1_ADDR);
                        res_data = nfcs_pkg::PROGRAM_CMD;
                    end
                    default: begin
                        res_addr = head_word;
                        res_data = head_cmd.data;
                    end
                endcase
            end
            nfcs_pkg::KIND_ERASE: begin
                case (step_reg)
                    3'd0, 3'd3: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK1_ADDR);
                        res_data = nfcs_pkg::UNLOCK1_DATA;
                    end
                    3'd1, 3'd4: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK2_ADDR);
                        res_data = nfcs_pkg::UNLOCK2_DATA;
                    end
                    3'd2: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK1_ADDR);
                        res_data = nfcs_pkg::ERASE_CMD;
                    end
                    default: begin
                        res_addr = head_word;
                        res_data = nfcs_pkg::SECTOR_CMD;
                    end
                endcase
            end
            nfcs_pkg::KIND_RESET: begin
                res_addr = WA'(nfcs_pkg::RESET_ADDR);
                res_data = nfcs_pkg::RESET_CMD;
            end
            nfcs_pkg::KIND_ID: begin
                case (step_reg)
                    3'd0: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK1_ADDR);
                        res_data = nfcs_pkg::UNLOCK1_DATA;
                    end
                    3'd1: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK2_ADDR);
                        res_data = nfcs_pkg::UNLOCK2_DATA;
                    end
                    default: begin
                        res_addr = WA'(nfcs_pkg::UNLOCK1_ADDR);
                        res_data = nfcs_pkg::ID_CMD;
                    end
                endcase
            end
            nfcs_pkg::KIND_CFI: begin
                res_addr = WA'(nfcs_pkg::CFI_ADDR);
                res_data = nfcs_pkg::CFI_CMD;
            end
            nfcs_pkg::KIND_POLL: begin
                res_wr  = 1'b0;
                res_rdy = head_cmd.rdy;
            end
            default: begin
                res_wr  = 1'b0;
                res_err = 1'b1;
            end
        endcase
        res_last = (step_reg == nfcs_pkg::last_step(head_cmd.kind));
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            step_next  = res_last ? '0 : step_reg + 1'b1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg <= res_addr;
            data_reg <= res_data;
            wr_reg   <= res_wr;
            rdy_reg  <= res_rdy;
            err_reg  <= res_err;
            last_reg <= res_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_addr  = addr_reg;
    assign out_data  = data_reg;
    assign out_wr    = wr_reg;
    assign out_rdy   = rdy_reg;
    assign out_err   = err_reg;
    assign out_last  = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) step_reg <= 3'd5)
        else $error("step counter out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (err_reg || rdy_reg) |-> !wr_reg && last_reg)
        else $error("status result marked as bus write or not last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> step_reg == '0)
        else $error("step not rewound after descriptor retired");

endmodule

### design/nor_flash_command_sequencer.sv
`timescale 1ns / 1ps
// Top level of the NOR flash command sequencer.
// Instantiates nfcs_front, nfcs_fifo and nfcs_back; uses nfcs_pkg.
//
// Usage:
//   The s_axis channel takes one request per beat: tuser holds the operation
//   (program halfword, sector erase, reset, ID entry, CFI entry, status poll),
//   tdata the byte address, write data, span and status read data. The
//   m_axis channel returns the results: each bus write of the JEDEC command
//   run (flash word address and data), a single range-error beat, or a poll
//   beat with the ready flag. tlast marks the final beat of each request.
//   cfg_wr_en/cfg_wr_data load flash_end; write it only while idle.
// Path: an accepted request enters the descriptor queue; its first result beat
//   is then registered into the output stage. Throughput: one result beat per
//   cycle from the back end while m_axis_tready is high; erase yields 6 beats,
//   program 4, ID entry 3, the rest 1. Requests that yield no beat are dropped.
//   The front keeps taking requests until the descriptor queue is full.
// Reset: clears flash_end to 2 MiB, the toggle history, queue and output.
// Stall: while m_axis_tready is low the output beat holds, the back end halts
//   and the queue fills; s_axis_tready drops once it is full.
module nor_flash_command_sequencer #(
    parameter int ADDRESS_BITS = 24,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration
    input  logic                                      cfg_wr_en,
    input  logic [nfcs_pkg::END_W-1:0]                cfg_wr_data,
    // request channel
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: byte_address, write_data[15:0], span[1:0], status_value[15:0], zero fill
    input  logic [((ADDRESS_BITS+34+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]                                s_axis_tuser,
    // result channel
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata: bus_word_address, bus_data[15:0], zero fill
    output logic [((ADDRESS_BITS-1+16+7)/8)*8-1:0]    m_axis_tdata,
    // tuser: bus_write, ready_res, range_error
    output logic [2:0]                                m_axis_tuser,
    output logic                                      m_axis_tlast
);

    localparam int WA     = ADDRESS_BITS - 1;
    localparam int S_W    = ((ADDRESS_BITS + 34 + 7) / 8) * 8;
    localparam int M_W    = ((WA + 16 + 7) / 8) * 8;
    localparam int Q_W    = WA + $bits(nfcs_pkg::cmd_t);

    logic                    in_fire;
    logic                    push, pop, q_full, q_empty;
    nfcs_pkg::cmd_t          front_cmd, head_cmd;
    logic [WA-1:0]           front_word, head_word;
    logic [Q_W-1:0]          head_bits;
    logic [WA-1:0]           out_addr;
    logic [15:0]             out_data;
    logic                    out_wr, out_rdy, out_err;

    // accept whenever the queue has room; results never block the front directly
    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    nfcs_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_fire      (in_fire),
        .operation    (s_axis_tuser),
        .byte_address (s_axis_tdata[ADDRESS_BITS-1:0]),
        .write_data   (s_axis_tdata[ADDRESS_BITS+15:ADDRESS_BITS]),
        .span         (s_axis_tdata[ADDRESS_BITS+17:ADDRESS_BITS+16]),
        .status_value (s_axis_tdata[ADDRESS_BITS+33:ADDRESS_BITS+18]),
        .push         (push),
        .cmd          (front_cmd),
        .cmd_word     (front_word)
    );

    // hold classified requests while the back end works through long runs
    nfcs_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({front_word, front_cmd}),
        .pop       (pop),
        .head_data (head_bits),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_word = head_bits[Q_W-1:$bits(nfcs_pkg::cmd_t)];
    assign head_cmd  = nfcs_pkg::cmd_t'(head_bits[$bits(nfcs_pkg::cmd_t)-1:0]);

    // expand one result beat per cycle, while m_axis_tready allows, into the output register
    nfcs_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_empty),
        .head_cmd   (head_cmd),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_addr   (out_addr),
        .out_data   (out_data),
        .out_wr     (out_wr),
        .out_rdy    (out_rdy),
        .out_err    (out_err),
        .out_last   (m_axis_tlast)
    );

    // pack result fields, lowest first, zero fill to whole bytes
    assign m_axis_tdata = M_W'({out_data, out_addr});
    assign m_axis_tuser = {out_err, out_rdy, out_wr};

    // a full queue must stop the request channel
    assert property (@(posedge aclk) disable iff (!aresetn) q_full |-> !s_axis_tready)
        else $error("request accepted into full queue");

    // results only come from queued descriptors
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && q_empty |=> !m_axis_tvalid)
        else $error("result beat without a queued request");

    // an error beat never carries a bus write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("range error beat malformed");

    // keep the input width check local: tdata must cover all fields
    assert property (@(posedge aclk) disable iff (!aresetn) S_W >= ADDRESS_BITS + 34)
        else $error("request tdata too narrow");

endmodule
